@@ design/lcdseq_pkg.sv @@
// Package for the character LCD nibble command sequencer.
// Holds the sequencer state type, request opcodes and display command codes.
// No dependencies.
`default_nettype none

package lcdseq_pkg;

   typedef enum logic [1:0] {
      OP_PUT_CHAR = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_INIT     = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_WRAP      = 11'b000_0000_0010,
      ST_LINE1     = 11'b000_0000_0100,
      ST_RIGHT     = 11'b000_0000_1000,
      ST_LEFT1     = 11'b000_0001_0000,
      ST_SPACE     = 11'b000_0010_0000,
      ST_LEFT2     = 11'b000_0100_0000,
      ST_DATA      = 11'b000_1000_0000,
      ST_CLEAR     = 11'b001_0000_0000,
      ST_INIT_NIB  = 11'b010_0000_0000,
      ST_INIT_BYTE = 11'b100_0000_0000
   } state_type;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;
   localparam logic [7:0] CMD_LINE1 = 8'h80;
   localparam logic [7:0] CMD_LINE2 = 8'hC0;
   localparam logic [7:0] CMD_RIGHT = 8'h14;
   localparam logic [7:0] CMD_LEFT  = 8'h10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
   localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

   localparam logic       RS_COMMAND = 1'b0;
   localparam logic       RS_DATA    = 1'b1;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h28;
         3'd1: b = 8'h0F;
         3'd2: b = 8'h01;
         3'd3: b = 8'h04;
         3'd4: b = 8'h06;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ design/lcdseq_req_if.sv @@
// Request channel: valid/ready handshake with opcode and character payload.
// Depends on nothing.
`default_nettype none

interface lcdseq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_code;

   modport source (output valid, output opcode, output char_code, input ready);
   modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

`default_nettype wire

@@ design/lcdseq_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one LCD bus nibble word.
// Depends on nothing.
`default_nettype none

interface lcdseq_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic [3:0] nibble;
   logic       last;

   modport source (output valid, output reg_select, output nibble, output last,
                   input ready);
   modport sink   (input valid, input reg_select, input nibble, input last,
                   output ready);
endinterface

`default_nettype wire

@@ design/char_lcd_nibble_command_sequencer.sv @@
// Character LCD nibble command sequencer top level.
// Depends on lcdseq_pkg, lcdseq_req_if and lcdseq_rsp_if.
// A taken request is registered into the step state, then each word into the response register.
// Throughput: one nibble word per cycle while a request is active and the sink is ready;
//   a request emits up to 2*ROW_WIDTH+10 words, and a new one is taken only once idle.
// The step sequencer and its single step counter set the word sequence.
// Reset: synchronous; clears cursor position, backspace code and sequencer.
`default_nettype none

module char_lcd_nibble_command_sequencer #(
   parameter int ROW_WIDTH   = 16,
   parameter int TOTAL_CHARS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   lcdseq_req_if.sink      req,
   lcdseq_rsp_if.source    rsp,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   localparam int CntW = $clog2(ROW_WIDTH);
   localparam logic [5:0] RowPos   = 6'(ROW_WIDTH);
   localparam logic [5:0] TotalPos = 6'(TOTAL_CHARS);
   localparam logic [CntW-1:0] RightLast = CntW'(ROW_WIDTH - 1);
   localparam logic [CntW-1:0] NibLast   = CntW'(3);
   localparam logic [CntW-1:0] ByteLast  = CntW'(4);

   lcdseq_pkg::state_type state_ff, state_in, first_state, next_step;

   logic [7:0]      bs_code_ff, bs_code_in;
   logic [5:0]      pos_ff, pos_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            half_ff, half_in;
   logic [7:0]      char_ff, char_in;
   logic [7:0]      wrap_byte_ff, wrap_byte_in;
   logic            is_bs_ff, is_bs_in;
   logic            erase_ff, erase_in;
   logic            line1_ff, line1_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_rs_ff, rsp_rs_in;
   logic [3:0]      rsp_nib_ff, rsp_nib_in;
   logic            rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       emit;
   logic       step_done;
   logic       single;
   logic       cur_rs;
   logic [7:0] cur_byte;
   logic [3:0] cur_nib;
   logic [3:0] out_nib;

   logic       wrap_line2, wrap_home, wrap_any, in_bs, in_erase, in_line1;
   logic [5:0] pos_eff;
   lcdseq_pkg::state_type in_after_wrap, reg_after_wrap;

   assign req.ready = (state_ff == lcdseq_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign emit      = (state_ff != lcdseq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.reg_select = rsp_rs_ff;
   assign rsp.nibble     = rsp_nib_ff;
   assign rsp.last       = rsp_last_ff;

   // decode the incoming request against the current position
   always_comb begin
      wrap_line2 = (pos_ff == RowPos);
      wrap_home  = !wrap_line2 && (pos_ff >= TotalPos);
      wrap_any   = wrap_line2 || wrap_home;
      pos_eff    = wrap_home ? 6'd0 : pos_ff;
      in_bs      = (req.char_code == bs_code_ff);
      in_erase   = in_bs && (pos_eff != 6'd0);
      in_line1   = in_erase && (pos_eff == RowPos);
      if (!in_bs) begin
         in_after_wrap = lcdseq_pkg::ST_DATA;
      end else if (in_line1) begin
         in_after_wrap = lcdseq_pkg::ST_LINE1;
      end else if (in_erase) begin
         in_after_wrap = lcdseq_pkg::ST_LEFT1;
      end else begin
         in_after_wrap = lcdseq_pkg::ST_IDLE;
      end
      case (req.opcode)
         lcdseq_pkg::OP_PUT_CHAR: first_state = wrap_any ? lcdseq_pkg::ST_WRAP : in_after_wrap;
         lcdseq_pkg::OP_CLEAR:    first_state = lcdseq_pkg::ST_CLEAR;
         lcdseq_pkg::OP_INIT:     first_state = lcdseq_pkg::ST_INIT_NIB;
         default:                 first_state = lcdseq_pkg::ST_IDLE;
      endcase
   end

   // current byte or single nibble for the active step
   always_comb begin
      single   = 1'b0;
      cur_rs   = lcdseq_pkg::RS_COMMAND;
      cur_byte = 8'h00;
      cur_nib  = lcdseq_pkg::INIT_NIB_WAKE;
      case (state_ff)
         lcdseq_pkg::ST_WRAP:  cur_byte = wrap_byte_ff;
         lcdseq_pkg::ST_LINE1: cur_byte = lcdseq_pkg::CMD_LINE1;
         lcdseq_pkg::ST_RIGHT: cur_byte = lcdseq_pkg::CMD_RIGHT;
         lcdseq_pkg::ST_LEFT1: cur_byte = lcdseq_pkg::CMD_LEFT;
         lcdseq_pkg::ST_SPACE: begin
            cur_rs   = lcdseq_pkg::RS_DATA;
            cur_byte = lcdseq_pkg::CHAR_SPACE;
         end
         lcdseq_pkg::ST_LEFT2: cur_byte = lcdseq_pkg::CMD_LEFT;
         lcdseq_pkg::ST_DATA: begin
            cur_rs   = lcdseq_pkg::RS_DATA;
            cur_byte = char_ff;
         end
         lcdseq_pkg::ST_CLEAR: cur_byte = lcdseq_pkg::CMD_CLEAR;
         lcdseq_pkg::ST_INIT_NIB: begin
            single  = 1'b1;
            cur_nib = (cnt_ff == NibLast) ? lcdseq_pkg::INIT_NIB_4BIT
                                          : lcdseq_pkg::INIT_NIB_WAKE;
         end
         lcdseq_pkg::ST_INIT_BYTE: cur_byte = lcdseq_pkg::init_byte(cnt_ff[2:0]);
         default: cur_byte = 8'h00;
      endcase
      out_nib   = single ? cur_nib : (half_ff ? cur_byte[3:0] : cur_byte[7:4]);
      step_done = single || half_ff;
   end

   // step that follows the active one once it is fully sent
   always_comb begin
      if (!is_bs_ff) begin
         reg_after_wrap = lcdseq_pkg::ST_DATA;
      end else if (line1_ff) begin
         reg_after_wrap = lcdseq_pkg::ST_LINE1;
      end else if (erase_ff) begin
         reg_after_wrap = lcdseq_pkg::ST_LEFT1;
      end else begin
         reg_after_wrap = lcdseq_pkg::ST_IDLE;
      end
      case (state_ff)
         lcdseq_pkg::ST_WRAP:  next_step = reg_after_wrap;
         lcdseq_pkg::ST_LINE1: next_step = lcdseq_pkg::ST_RIGHT;
         lcdseq_pkg::ST_RIGHT: next_step = (cnt_ff == RightLast) ? lcdseq_pkg::ST_LEFT1
                                                                 : lcdseq_pkg::ST_RIGHT;
         lcdseq_pkg::ST_LEFT1: next_step = lcdseq_pkg::ST_SPACE;
         lcdseq_pkg::ST_SPACE: next_step = lcdseq_pkg::ST_LEFT2;
         lcdseq_pkg::ST_INIT_NIB: next_step = (cnt_ff == NibLast) ? lcdseq_pkg::ST_INIT_BYTE
                                                                  : lcdseq_pkg::ST_INIT_NIB;
         lcdseq_pkg::ST_INIT_BYTE: next_step = (cnt_ff == ByteLast) ? lcdseq_pkg::ST_CLEAR
                                                                    : lcdseq_pkg::ST_INIT_BYTE;
         default: next_step = lcdseq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      half_in      = half_ff;
      pos_in       = pos_ff;
      char_in      = char_ff;
      wrap_byte_in = wrap_byte_ff;
      is_bs_in     = is_bs_ff;
      erase_in     = erase_ff;
      line1_in     = line1_ff;
      bs_code_in   = csr_we ? csr_wdata : bs_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_rs_in    = rsp_rs_ff;
      rsp_nib_in   = rsp_nib_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         state_in     = first_state;
         cnt_in       = '0;
         half_in      = 1'b0;
         char_in      = req.char_code;
         wrap_byte_in = wrap_line2 ? lcdseq_pkg::CMD_LINE2 : lcdseq_pkg::CMD_HOME;
         is_bs_in     = in_bs;
         erase_in     = in_erase;
         line1_in     = in_line1;
         case (req.opcode)
            lcdseq_pkg::OP_PUT_CHAR: begin
               if (!in_bs) begin
                  pos_in = pos_eff + 6'd1;
               end else if (in_erase) begin
                  pos_in = pos_eff - 6'd1;
               end else begin
                  pos_in = pos_eff;
               end
            end
            lcdseq_pkg::OP_CLEAR: pos_in = 6'd0;
            lcdseq_pkg::OP_INIT:  pos_in = 6'd0;
            default:              pos_in = pos_ff;
         endcase
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_rs_in    = cur_rs;
         rsp_nib_in   = out_nib;
         rsp_last_in  = step_done && (next_step == lcdseq_pkg::ST_IDLE);
         if (!step_done) begin
            half_in = 1'b1;
         end else begin
            half_in  = 1'b0;
            state_in = next_step;
            cnt_in   = (next_step == state_ff) ? cnt_ff + CntW'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdseq_pkg::ST_IDLE;
         pos_ff       <= 6'd0;
         bs_code_ff   <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bs_code_ff   <= bs_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      half_ff      <= half_in;
      char_ff      <= char_in;
      wrap_byte_ff <= wrap_byte_in;
      is_bs_ff     <= is_bs_in;
      erase_ff     <= erase_in;
      line1_ff     <= line1_in;
      rsp_rs_ff    <= rsp_rs_in;
      rsp_nib_ff   <= rsp_nib_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

@@ design/lcdseq_checker.sv @@
// Port-level checker for the character LCD nibble command sequencer.
// Depends on lcdseq_pkg; bound to char_lcd_nibble_command_sequencer below.
`default_nettype none

module lcdseq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_opcode,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_reg_select,
   input wire logic [3:0] rsp_nibble,
   input wire logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nibble)
         && $stable(rsp_reg_select) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_busy_mid_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before previous request finished");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == lcdseq_pkg::OP_CLEAR) |=> !req_ready)
      else $error("clear request finished without emitting");

   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == lcdseq_pkg::OP_INIT)
         |=> !req_ready ##1 !req_ready)
      else $error("init request finished too early");

   a_data_word_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !(rsp_valid && rsp_last && !$past(req_valid)))
      else $error("last mark repeated without a new request");

endmodule

bind char_lcd_nibble_command_sequencer lcdseq_checker u_lcdseq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_opcode     (req.opcode),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_reg_select (rsp.reg_select),
   .rsp_nibble     (rsp.nibble),
   .rsp_last       (rsp.last)
);

`default_nettype wire

@@ test/lcd_word_checker.sv @@
`timescale 1ns / 100ps
// Checker for the character LCD nibble command sequencer: tracks cursor position and
// backspace code, predicts the bus words of each request and compares them in order.
// Depends on lcdseq_pkg and the request and response channel interfaces.
module lcd_word_checker #(
   parameter int ROW_WIDTH   = 16,
   parameter int TOTAL_CHARS = 32
) (
   input  logic       clock,
   input  logic       reset,
   lcdseq_req_if      req,
   lcdseq_rsp_if      rsp,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         words_pending,
   output int         mismatch_count
);

   localparam logic [7:0] FUNC_SET_4BIT_2LINE = 8'h28;
   localparam logic [7:0] DISPLAY_ON_BLINK    = 8'h0F;
   localparam logic [7:0] ENTRY_MODE_DEC      = 8'h04;
   localparam logic [7:0] ENTRY_MODE_INC      = 8'h06;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       last;
   } bus_word_type;

   bus_word_type pending_bus_words[$];
   logic [5:0]   cursor_pos;
   logic [7:0]   erase_code;

   function automatic void push_nibble(input logic rs, input logic [3:0] nib);
      bus_word_type w;
      w.reg_select = rs;
      w.nibble     = nib;
      w.last       = 1'b0;
      pending_bus_words.push_back(w);
   endfunction

   function automatic void push_byte(input logic rs, input logic [7:0] b);
      push_nibble(rs, b[7:4]);
      push_nibble(rs, b[3:0]);
   endfunction

   function automatic void plan_bus_words(input lcdseq_pkg::opcode_type op,
                                          input logic [7:0] ch);
      int         first;
      logic [5:0] pos;
      first = pending_bus_words.size();
      pos   = cursor_pos;
      case (op)
         lcdseq_pkg::OP_PUT_CHAR: begin
            if (pos == ROW_WIDTH) begin
               push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_LINE2);
            end else if (pos >= TOTAL_CHARS) begin
               pos = '0;
               push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_HOME);
            end
            if (ch == erase_code) begin
               if (pos != 0) begin
                  if (pos == ROW_WIDTH) begin
                     push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_LINE1);
                     repeat (ROW_WIDTH)
                        push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_RIGHT);
                  end
                  push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_LEFT);
                  push_byte(lcdseq_pkg::RS_DATA, lcdseq_pkg::CHAR_SPACE);
                  push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_LEFT);
                  pos = pos - 6'd1;
               end
            end else begin
               push_byte(lcdseq_pkg::RS_DATA, ch);
               pos = pos + 6'd1;
            end
            cursor_pos = pos;
         end
         lcdseq_pkg::OP_CLEAR: begin
            push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_CLEAR);
            cursor_pos = '0;
         end
         lcdseq_pkg::OP_INIT: begin
            push_nibble(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::INIT_NIB_WAKE);
            push_nibble(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::INIT_NIB_WAKE);
            push_nibble(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::INIT_NIB_WAKE);
            push_nibble(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::INIT_NIB_4BIT);
            push_byte(lcdseq_pkg::RS_COMMAND, FUNC_SET_4BIT_2LINE);
            push_byte(lcdseq_pkg::RS_COMMAND, DISPLAY_ON_BLINK);
            push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_CLEAR);
            push_byte(lcdseq_pkg::RS_COMMAND, ENTRY_MODE_DEC);
            push_byte(lcdseq_pkg::RS_COMMAND, ENTRY_MODE_INC);
            push_byte(lcdseq_pkg::RS_COMMAND, lcdseq_pkg::CMD_CLEAR);
            cursor_pos = '0;
         end
         default: begin
         end
      endcase
      if (pending_bus_words.size() > first)
         pending_bus_words[pending_bus_words.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      bus_word_type want;
      if (reset) begin
         pending_bus_words.delete();
         cursor_pos = '0;
         erase_code = '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_bus_words.size() == 0) begin
               $error("unexpected word: reg_select %0d nibble %h last %0d",
                      rsp.reg_select, rsp.nibble, rsp.last);
               mismatch_count++;
            end else begin
               want = pending_bus_words.pop_front();
               if (rsp.reg_select !== want.reg_select) begin
                  $error("reg_select: expected %0d, got %0d", want.reg_select, rsp.reg_select);
                  mismatch_count++;
               end
               if (rsp.nibble !== want.nibble) begin
                  $error("nibble: expected %h, got %h", want.nibble, rsp.nibble);
                  mismatch_count++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp.last);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready)
            plan_bus_words(lcdseq_pkg::opcode_type'(req.opcode), req.char_code);
         if (csr_we)
            erase_code = csr_wdata;
      end
      words_pending = pending_bus_words.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Top of the character LCD sequencer testbench: makes requests, backspace code writes
// and result back-pressure in phases, then gives the verdict from lcd_word_checker.
// Depends on lcdseq_pkg, the channel interfaces, the sequencer and lcd_word_checker.
module tb;

   localparam int ROW_CELLS     = 16;
   localparam int TOTAL_CELLS   = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 50;
   localparam int PHASE_ITEMS   = 100;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;
   logic [7:0] erase_code_now;
   int         send_idle_pct;
   int         stall_pct;
   int         words_pending;
   int         mismatch_count;
   bit         hold_request;

   lcdseq_req_if req_bus();
   lcdseq_rsp_if rsp_bus();

   char_lcd_nibble_command_sequencer #(
      .ROW_WIDTH  (ROW_CELLS),
      .TOTAL_CHARS(TOTAL_CELLS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   lcd_word_checker #(
      .ROW_WIDTH  (ROW_CELLS),
      .TOTAL_CHARS(TOTAL_CELLS)
   ) word_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .words_pending (words_pending),
      .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(input lcdseq_pkg::opcode_type op, input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.char_code <= ch;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_erase_code(input logic [7:0] code);
      csr_we         <= 1'b1;
      csr_wdata      <= code;
      erase_code_now = code;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      logic [3:0] k;
      send_request(lcdseq_pkg::OP_INIT, 8'h00);
      send_request(lcdseq_pkg::OP_NONE, 8'hFF);
      send_request(lcdseq_pkg::OP_PUT_CHAR, erase_code_now);
      send_request(lcdseq_pkg::OP_PUT_CHAR, 8'hFF);
      for (k = 4'd1; k != 4'd0; k++)
         send_request(lcdseq_pkg::OP_PUT_CHAR, {k, ~k});
      send_request(lcdseq_pkg::OP_PUT_CHAR, erase_code_now);
      send_request(lcdseq_pkg::OP_PUT_CHAR, erase_code_now);
      send_request(lcdseq_pkg::OP_CLEAR, 8'h5A);
   endtask

   task automatic run_phase(input logic [7:0] code, input int idle_pct, input int stall,
                            input bit long_hold);
      int n;
      int pick;
      drain();
      write_erase_code(code);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (long_hold)
         hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 1)
            send_request(lcdseq_pkg::OP_INIT, 8'($urandom_range(255)));
         else if (pick < 2)
            send_request(lcdseq_pkg::OP_CLEAR, 8'($urandom_range(255)));
         else if (pick < 4)
            send_request(lcdseq_pkg::OP_NONE, 8'($urandom_range(255)));
         else if (pick < 16)
            send_request(lcdseq_pkg::OP_PUT_CHAR, erase_code_now);
         else
            send_request(lcdseq_pkg::OP_PUT_CHAR, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = lcdseq_pkg::OP_NONE;
      req_bus.char_code = '0;
      erase_code_now    = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_request      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(8'hFF, 0, 0, 1'b0);
      run_phase(8'h08, 64, 0, 1'b0);
      run_phase(8'($urandom_range(255)), 0, 64, 1'b1);
      run_phase(8'h00, 23, 23, 1'b0);
      run_phase(8'($urandom_range(255)), 0, 0, 1'b0);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
